// ===== sv/oas_pkg.sv =====
package oas_pkg;

   localparam int CHANNELS = 3;
   localparam int WINDOW   = 8;
   localparam int SLOTS    = WINDOW + 1;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int CH_W      = 2;
   localparam int SAMPLE_W  = 16;
   localparam int CODE_W    = 16;
   localparam int COARSE_W  = 8;
   localparam int MAG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [SAMPLE_W-1:0] MID_RESET   = 16'd4096;
   localparam logic [MAG_W-1:0]    LIMIT_RESET = 7'h64;
   localparam logic [COARSE_W-1:0] NEG_ZERO    = 8'h80;
   localparam logic [CODE_W-1:0]   FINE_MAX    = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MID_THRESHOLD = 1'b0,
      REG_COARSE_LIMIT  = 1'b1
   } oas_reg_type;

   typedef struct packed {
      logic load;
      logic step;
      logic scan;
      logic publish;
   } oas_cmd_type;

   typedef struct packed {
      logic ch_ok;
      logic scan_last;
      logic out_free;
   } oas_status_type;

endpackage

// ===== sv/oas_if.sv =====
interface oas_req_if;
   import oas_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [CH_W-1:0]     channel;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, operation, channel, sample, input ready);
   modport sink (input valid, operation, channel, sample, output ready);
endinterface

interface oas_rsp_if;
   import oas_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code;
   logic              write_request;
   logic              settled;
   modport source (output valid, code, write_request, settled, input ready);
   modport sink (input valid, code, write_request, settled, output ready);
endinterface

interface oas_csr_if;
   import oas_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/offset_autocal_stepper_top.sv =====
// channel   direction  payload
// req_bus   in         operation, channel, sample
// rsp_bus   out        code, write_request, settled
// csr_bus   in         index (0 mid_threshold, 1 coarse_limit), data; always ready
//
// an item is accepted only in idle and runs through accept, code update and
// window write, a walk comparing each window slot with the new code, then publish;
// the result is registered in the output register at publish
// the window walk runs through one comparator; a bad channel skips the update and walk
// reset restores config defaults and clears all codes, the window and fill state
// a result held by rsp_bus.ready low stalls the next publish; the next item is
// accepted while a finished result still waits in the output register
module offset_autocal_stepper_top
   import oas_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   oas_req_if.sink   req_bus,
   oas_rsp_if.source rsp_bus,
   oas_csr_if.sink   csr_bus
);

   oas_cmd_type    cmd;
   oas_status_type status;
   logic           req_ready;

   assign req_bus.ready = req_ready;

   oas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   oas_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_bus.operation),
      .req_channel   (req_bus.channel),
      .req_sample    (req_bus.sample),
      .csr           (csr_bus),
      .rsp           (rsp_bus),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

// ===== sv/oas_ctrl.sv =====
module oas_ctrl
   import oas_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  oas_status_type status,
   output oas_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_STEP   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // out-of-range channel leaves codes, window and fill state alone
            if (status.ch_ok) begin
               cmd.step = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/oas_datapath.sv =====
module oas_datapath
   import oas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_operation,
   input  logic [CH_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0] req_sample,
   oas_csr_if.sink             csr,
   oas_rsp_if.source           rsp,
   input  oas_cmd_type         cmd,
   output oas_status_type      status
);

   function automatic logic [COARSE_W-1:0] coarse_step(
      input logic [COARSE_W-1:0] c,
      input logic                below,
      input logic [MAG_W-1:0]    limit
   );
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic [MAG_W-1:0] grown;
      mag   = c[MAG_W-1:0];
      neg   = c[COARSE_W-1];
      grown = (mag < limit) ? mag + 1'b1 : mag;
      if (below) begin
         if (!neg)          coarse_step = {1'b0, grown};
         else if (mag != 0) coarse_step = {1'b1, mag - 1'b1};
         else               coarse_step = '0;
      end else begin
         if (neg)           coarse_step = {1'b1, grown};
         else if (mag != 0) coarse_step = {1'b0, mag - 1'b1};
         else               coarse_step = NEG_ZERO;
      end
   endfunction

   logic [SAMPLE_W-1:0] mid_ff;
   logic [MAG_W-1:0]    limit_ff;

   logic                op_ff;
   logic [CH_W-1:0]     ch_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   logic [COARSE_W-1:0] coarse_ff [CHANNELS];
   logic [CODE_W-1:0]   fine_ff [CHANNELS];
   logic [CODE_W-1:0]   hist_ff [SLOTS];
   logic [SLOT_W-1:0]   fill_ff, fill_in;
   logic                full_ff, full_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic                all_ff, all_in;
   logic [CODE_W-1:0]   code_ff, code_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic                rsp_wreq_ff;
   logic                rsp_settled_ff;

   logic                ch_ok;
   logic                below;
   logic [COARSE_W-1:0] coarse_new;
   logic [CODE_W-1:0]   fine_cur;
   logic [CODE_W-1:0]   fine_new;
   logic [CODE_W:0]     diff;
   logic                near;
   logic                stable;

   assign ch_ok = (int'(ch_ff) < CHANNELS);
   assign below = (sample_ff < mid_ff);

   assign coarse_new = coarse_step(coarse_ff[ch_ff], below, limit_ff);
   assign fine_cur   = fine_ff[ch_ff];
   always_comb begin
      if (below) fine_new = (fine_cur != '0) ? fine_cur - 1'b1 : fine_cur;
      else       fine_new = (fine_cur != FINE_MAX) ? fine_cur + 1'b1 : fine_cur;
   end

   // within one step: difference is 0, +1 or -1
   assign diff   = {1'b0, hist_ff[scan_ff]} - {1'b0, code_ff};
   assign near   = (diff == '0) || (diff == (CODE_W+1)'(1)) || (&diff);
   assign stable = full_ff && all_ff;

   always_comb begin
      fill_in = fill_ff;
      full_in = full_ff;
      scan_in = scan_ff;
      all_in  = all_ff;
      code_in = code_ff;
      if (cmd.step) begin
         code_in = op_ff ? fine_new : {{(CODE_W-COARSE_W){1'b0}}, coarse_new};
         scan_in = '0;
         all_in  = 1'b1;
         if (fill_ff == SLOT_W'(SLOTS - 1)) begin
            fill_in = '0;
            full_in = 1'b1;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.scan) begin
         all_in  = all_ff && near;
         if (scan_ff != SLOT_W'(SLOTS - 1)) scan_in = scan_ff + 1'b1;
      end
      // a settled window starts filling again
      if (cmd.publish && ch_ok && stable) full_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)    rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   assign status.ch_ok     = ch_ok;
   assign status.scan_last = (scan_ff == SLOT_W'(SLOTS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.code          = rsp_code_ff;
   assign rsp.write_request = rsp_wreq_ff;
   assign rsp.settled       = rsp_settled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= MID_RESET;
         limit_ff     <= LIMIT_RESET;
         fill_ff      <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            coarse_ff[i] <= '0;
            fine_ff[i]   <= '0;
         end
         for (int i = 0; i < SLOTS; i++) hist_ff[i] <= '0;
      end else begin
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            unique case (oas_reg_type'(csr.index))
               REG_MID_THRESHOLD: mid_ff   <= csr.data[SAMPLE_W-1:0];
               REG_COARSE_LIMIT:  limit_ff <= csr.data[MAG_W-1:0];
               default: ;
            endcase
         end
         if (cmd.step) begin
            if (op_ff) fine_ff[ch_ff]   <= fine_new;
            else       coarse_ff[ch_ff] <= coarse_new;
            hist_ff[fill_ff] <= code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      all_ff  <= all_in;
      code_ff <= code_in;
      if (cmd.load) begin
         op_ff     <= req_operation;
         ch_ff     <= req_channel;
         sample_ff <= req_sample;
      end
      if (cmd.publish) begin
         rsp_code_ff    <= ch_ok ? code_ff : '0;
         rsp_wreq_ff    <= ch_ok && full_ff && !all_ff;
         rsp_settled_ff <= ch_ok && stable;
      end
   end

endmodule

// ===== sv/oas_checker.sv =====
module oas_checker
   import oas_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_write_request,
   input logic rsp_settled
);

   // one item in flight: intake closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_write_request && rsp_settled))
      else $error("write_request and settled both set");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after accept");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind offset_autocal_stepper_top oas_checker u_oas_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_write_request (rsp_bus.write_request),
   .rsp_settled       (rsp_bus.settled)
);
